// File: src/wnst_pkg.sv
// Shared types and codes for the weighted neighbour sorted table.
// Used by the cell, the top level and the port checker; no dependencies.
package wnst_pkg;

  localparam int unsigned MAX_LISTED = 16;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STATUS_LISTED = 2'd0;
  localparam logic [1:0] STATUS_NONE   = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic remove_seen;
    logic insert_seen;
  } chain_t;

endpackage

// File: src/wnst_cell.sv
// One slot of the sorted chain: holds an id, a weight and a valid bit.
// Depends on wnst_pkg; takes data from either neighbour as the op says.
module wnst_cell import wnst_pkg::*; #(
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_op_t               op,
  input  logic [ID_BITS-1:0]     key_id,
  input  logic [WEIGHT_BITS-1:0] key_weight,
  input  chain_t                 chain_in,
  output chain_t                 chain_out,
  input  logic                   left_valid,
  input  logic [ID_BITS-1:0]     left_id,
  input  logic [WEIGHT_BITS-1:0] left_weight,
  input  logic                   right_valid,
  input  logic [ID_BITS-1:0]     right_id,
  input  logic [WEIGHT_BITS-1:0] right_weight,
  output logic                   valid,
  output logic [ID_BITS-1:0]     id,
  output logic [WEIGHT_BITS-1:0] weight
);

  logic                   match;
  logic                   goes_here;
  logic                   valid_next;
  logic [ID_BITS-1:0]     id_next;
  logic [WEIGHT_BITS-1:0] weight_next;

  assign match     = valid && (id == key_id);
  assign goes_here = !valid || (key_weight > weight) ||
                     ((key_weight == weight) && (key_id > id));

  assign chain_out.remove_seen = chain_in.remove_seen | match;
  assign chain_out.insert_seen = chain_in.insert_seen | goes_here;

  always_comb begin
    valid_next  = valid;
    id_next     = id;
    weight_next = weight;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_REMOVE: begin
        if (chain_out.remove_seen) begin
          valid_next  = right_valid;
          id_next     = right_id;
          weight_next = right_weight;
        end
      end
      CELL_INSERT: begin
        if (chain_in.insert_seen) begin
          valid_next  = left_valid;
          id_next     = left_id;
          weight_next = left_weight;
        end else if (goes_here) begin
          valid_next  = 1'b1;
          id_next     = key_id;
          weight_next = key_weight;
        end
      end
      CELL_ROTATE: begin
        valid_next  = right_valid;
        id_next     = right_id;
        weight_next = right_weight;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    id     <= id_next;
    weight <= weight_next;
  end

endmodule

// File: src/weighted_neighbour_sorted_table.sv
// Channel  Dir  Fields
// s_*      in   tuser: opcode; tdata: peer_id[15:0], weight[31:16]
// m_*      out  tuser: status; tlast: last; tdata: entry_id, entry_weight, rank
//
// A set drops a matching id in the accept cycle and inserts in order in the next.
// A query rotates the cell chain CAPACITY times after the accept cycle, one listed
// item per cycle while the output does not stall; the chain is restored at the end.
// A set rejected as full waits after the accept cycle for the output register.
// Reset clears every valid bit at once; no clearing pass is needed.
// Top level of the sorted table; depends on wnst_pkg and wnst_cell.
module weighted_neighbour_sorted_table import wnst_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // peer_id[15:0], weight[31:16]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // entry_id[15:0], entry_weight[31:16], rank[35:32], zeros
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_QUERY,
    S_REJECT
  } state_t;

  state_t                 state;
  logic [ID_BITS-1:0]     set_id;
  logic [WEIGHT_BITS-1:0] min_weight;
  logic [SW-1:0]          step;
  logic                   done;

  logic [ID_BITS-1:0]     in_id;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [ID_BITS-1:0]     key_id;
  logic [WEIGHT_BITS-1:0] key_weight;
  cell_op_t               op;

  logic                   cv [CAPACITY];
  logic [ID_BITS-1:0]     cid [CAPACITY];
  logic [WEIGHT_BITS-1:0] cw [CAPACITY];
  chain_t                 chain [CAPACITY+1];

  logic accept;
  logic out_free;
  logic found;
  logic full;
  logic qual0;
  logic qual1;
  logic emit_now;
  logic advance;
  logic entry_last;
  logic load_out;

  assign in_id     = ID_BITS'(s_tdata[15:0]);
  assign in_weight = WEIGHT_BITS'(s_tdata[31:16]);
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign key_id     = (state == S_IDLE) ? in_id : set_id;
  assign key_weight = (state == S_IDLE) ? in_weight : min_weight;

  assign chain[0] = '0;
  assign found    = chain[CAPACITY].remove_seen;
  assign full     = cv[CAPACITY-1];

  assign qual0      = cv[0] && (cw[0] >= min_weight);
  assign qual1      = cv[1] && (cw[1] >= min_weight);
  assign emit_now   = !done && (qual0 || (step == '0));
  assign advance    = !emit_now || out_free;
  assign entry_last = !qual1 || (step == SW'(CAPACITY-1)) ||
                      (32'(step) == 32'(MAX_LISTED-1));
  assign load_out   = ((state == S_QUERY) && advance && emit_now) ||
                      ((state == S_REJECT) && out_free);

  always_comb begin
    op = CELL_HOLD;
    unique case (state)
      S_IDLE: begin
        if (accept && (s_tuser == OP_SET) && (found || !full)) begin
          op = CELL_REMOVE;
        end
      end
      S_INSERT: op = CELL_INSERT;
      S_QUERY: begin
        if (advance) begin
          op = CELL_ROTATE;
        end
      end
      S_REJECT: op = CELL_HOLD;
      default: op = CELL_HOLD;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                   lv;
    logic [ID_BITS-1:0]     lid;
    logic [WEIGHT_BITS-1:0] lw;
    logic                   rv;
    logic [ID_BITS-1:0]     rid;
    logic [WEIGHT_BITS-1:0] rw;

    if (g == 0) begin : g_left_edge
      assign lv  = 1'b0;
      assign lid = '0;
      assign lw  = '0;
    end else begin : g_left
      assign lv  = cv[g-1];
      assign lid = cid[g-1];
      assign lw  = cw[g-1];
    end

    if (g == CAPACITY-1) begin : g_right_edge
      assign rv  = (op == CELL_ROTATE) ? cv[0] : 1'b0;
      assign rid = cid[0];
      assign rw  = cw[0];
    end else begin : g_right
      assign rv  = cv[g+1];
      assign rid = cid[g+1];
      assign rw  = cw[g+1];
    end

    wnst_cell #(
      .ID_BITS     (ID_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (op),
      .key_id       (key_id),
      .key_weight   (key_weight),
      .chain_in     (chain[g]),
      .chain_out    (chain[g+1]),
      .left_valid   (lv),
      .left_id      (lid),
      .left_weight  (lw),
      .right_valid  (rv),
      .right_id     (rid),
      .right_weight (rw),
      .valid        (cv[g]),
      .id           (cid[g]),
      .weight       (cw[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      done     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            set_id     <= in_id;
            min_weight <= in_weight;
            step       <= '0;
            done       <= 1'b0;
            if (s_tuser == OP_QUERY) begin
              state <= S_QUERY;
            end else if (found || !full) begin
              state <= S_INSERT;
            end else begin
              state <= S_REJECT;
            end
          end
        end
        S_INSERT: state <= S_IDLE;
        S_QUERY: begin
          if (advance) begin
            if (emit_now) begin
              m_tlast  <= entry_last || !qual0;
              done     <= entry_last || !qual0;
              if (qual0) begin
                m_tuser <= STATUS_LISTED;
                m_tdata <= {4'd0, 4'(step), 16'(cw[0]), 16'(cid[0])};
              end else begin
                m_tuser <= STATUS_NONE;
                m_tdata <= '0;
              end
            end
            step <= step + 1'b1;
            if (step == SW'(CAPACITY-1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_REJECT: begin
          if (out_free) begin
            m_tuser  <= STATUS_FULL;
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/wnst_checker.sv
// Port-level checks for the weighted neighbour sorted table, bound to the top.
// Depends on wnst_pkg for status codes.
module wnst_checker import wnst_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled output item changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STATUS_LISTED) || (m_tuser == STATUS_NONE) ||
                 (m_tuser == STATUS_FULL))
    else $error("unknown status code");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STATUS_LISTED) |-> m_tlast && (m_tdata == '0))
    else $error("status item not last or carries data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous item still at work");

endmodule

bind weighted_neighbour_sorted_table wnst_checker u_wnst_checker (.*);
